/* hdl/aoce_pkg.sv */
// Package for the offset-chained AES-192 encryptor.
// Holds the S-box, GF(2^8) helpers and shared constants; used by all modules.
package aoce_pkg;

	localparam int BlockBits = 128;
	localparam int KeyBits = 192;
	localparam int RoundCount = 12;
	localparam int BlocksPerChunk = 255;
	localparam int CfgIdxBits = 2;
	localparam logic [CfgIdxBits-1:0] RegKeyHigh = 2'd0;
	localparam logic [CfgIdxBits-1:0] RegKeyMid = 2'd1;
	localparam logic [CfgIdxBits-1:0] RegKeyLow = 2'd2;

	typedef logic [BlockBits-1:0] block_t;
	typedef logic [KeyBits-1:0] key_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] gf_double(input logic [7:0] a);
		gf_double = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte k of a block, byte 0 in the top bits.
	function automatic logic [7:0] byte_of(input block_t b, input int k);
		byte_of = b[BlockBits-1-8*k -: 8];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

/* hdl/aoce_key_sched.sv */
// On-the-fly AES-192 key schedule: produces one 128-bit round key per step.
// Depends on aoce_pkg. Keeps a sliding window of eight schedule words.
module aoce_key_sched (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  aoce_pkg::key_t key,
	input  logic          step,
	output aoce_pkg::block_t round_key
);
	import aoce_pkg::*;

	// Window holds words w[4r .. 4r+7]; its upper four words are round key r+1.
	logic [31:0] win_q [8];
	logic [7:0]  rcon_q;
	logic [1:0]  phase_q;
	logic [31:0] nxt [4];
	logic [7:0]  rcon_n;
	logic [31:0] ld_w6;
	logic [31:0] ld_w7;

	assign round_key = {win_q[4], win_q[5], win_q[6], win_q[7]};

	// Words w[6] and w[7] straight from the key, so the window is full after load.
	assign ld_w6 = key[KeyBits-1 -: 32] ^ sub_word({key[23:0], key[31:24]}) ^ 32'h01000000;
	assign ld_w7 = key[KeyBits-33 -: 32] ^ ld_w6;

	// Generate the next four words w[4r+8 .. 4r+11]; phase 0 substitutes the first,
	// phase 1 the third, phase 2 none.
	always_comb begin
		logic [31:0] t;
		logic [7:0]  rc;
		rc = rcon_q;
		for (int i = 0; i < 4; i++) begin
			t = (i == 0) ? win_q[7] : nxt[i-1];
			if (((phase_q == 2'd0) && (i == 0)) || ((phase_q == 2'd1) && (i == 2))) begin
				t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_double(rc);
			end
			nxt[i] = win_q[i+2] ^ t;
		end
		rcon_n = rc;
	end

	// Load the key or advance the window by four words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcon_q <= 8'h01;
			phase_q <= '0;
			for (int i = 0; i < 8; i++) win_q[i] <= '0;
		end else if (load) begin
			rcon_q <= 8'h02;
			phase_q <= 2'd2;
			for (int i = 0; i < 6; i++) win_q[i] <= key[KeyBits-1-32*i -: 32];
			win_q[6] <= ld_w6;
			win_q[7] <= ld_w7;
		end else if (step) begin
			rcon_q <= rcon_n;
			phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
			for (int i = 0; i < 4; i++) win_q[i] <= win_q[i+4];
			for (int i = 0; i < 4; i++) win_q[i+4] <= nxt[i];
		end
	end

endmodule

/* hdl/aoce_round.sv */
// One AES encryption round (SubBytes, ShiftRows, optional MixColumns, AddRoundKey).
// Depends on aoce_pkg. Pure logic, shared over all twelve rounds.
module aoce_round (
	input  aoce_pkg::block_t state_in,
	input  aoce_pkg::block_t round_key,
	input  logic             last,
	output aoce_pkg::block_t state_out
);
	import aoce_pkg::*;

	logic [7:0] t [16];
	logic [7:0] m [16];

	// Substitute and shift rows.
	always_comb begin
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				t[k+4*c] = SBOX[byte_of(state_in, k + 4*((c+k)%4))];
	end

	// Mix columns unless this is the final round.
	always_comb begin
		logic [7:0] all;
		for (int c = 0; c < 4; c++) begin
			all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
			for (int k = 0; k < 4; k++)
				m[4*c+k] = last ? t[4*c+k]
					: t[4*c+k] ^ all ^ gf_double(t[4*c+k] ^ t[4*c+((k+1)%4)]);
		end
		for (int k = 0; k < 16; k++)
			state_out[BlockBits-1-8*k -: 8] = m[k] ^ byte_of(round_key, k);
	end

endmodule

/* hdl/aes192_offset_chain_encrypt_top.sv */
// Offset-chained AES-192 encryptor, top level. Uses aoce_pkg, aoce_key_sched, aoce_round.
// Each request: whitening on accept, then the 12 rounds on one round unit.
// A new request is accepted only once the previous block has left the rounds.
// The result register frees the input while a result waits; the last round stalls only
// while the previous result is still unaccepted.
// Reset (arst_n, async low) clears key, chain value, block count and control state.
module aes192_offset_chain_encrypt_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // plain_low[63:0], plain_high[127:64]
	input  logic         s_tuser,   // restart
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // cipher_low[63:0], cipher_high[127:64]
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_wdata
);
	import aoce_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StRun  = 2'd1;

	logic [1:0]  state_q;
	logic [3:0]  round_q;
	logic [7:0]  count_q;
	logic        out_valid_q;
	key_t        key_q;
	block_t      chain_q;
	block_t      data_q;
	block_t      rk;
	block_t      rnd_out;
	logic        ks_load;
	logic        ks_step;
	logic        clear;
	block_t      offs;
	logic        accept;
	logic        last_round;
	logic        run_adv;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == StIdle);
	assign m_tvalid = out_valid_q;
	assign m_tdata = chain_q;
	assign clear = s_tuser || (count_q >= 8'(BlocksPerChunk));
	assign last_round = (round_q == 4'(RoundCount));

	// Advance a round; hold the last one while the previous result still waits.
	assign run_adv = (state_q == StRun) && (!last_round || !out_valid_q || m_tready);

	// Reload the schedule on each new request; step once per round.
	assign ks_load = accept;
	assign ks_step = run_adv;

	aoce_key_sched u_ks (
		.clk(clk), .arst_n(arst_n), .load(ks_load), .key(key_q),
		.step(ks_step), .round_key(rk)
	);

	aoce_round u_round (
		.state_in(data_q), .round_key(rk), .last(last_round),
		.state_out(rnd_out)
	);

	// Chain offset: previous result byte j (zero when a restart or a full chunk clears the chain) minus j.
	always_comb begin
		for (int j = 0; j < 16; j++)
			offs[BlockBits-1-8*j -: 8] = (clear ? 8'h00 : byte_of(chain_q, j)) - 8'(j);
	end

	// Key register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegKeyHigh: key_q[191:128] <= cfg_wdata;
				RegKeyMid:  key_q[127:64] <= cfg_wdata;
				RegKeyLow:  key_q[63:0] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer: whitening on accept, rounds 1..12, then write the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			round_q <= '0;
			count_q <= '0;
			chain_q <= '0;
		end else begin
			unique case (state_q)
				StIdle: if (accept) begin
					state_q <= StRun;
					round_q <= 4'd1;
					count_q <= clear ? 8'd1 : count_q + 8'd1;
				end
				StRun: if (run_adv) begin
					if (last_round) begin
						state_q <= StIdle;
						chain_q <= rnd_out;
					end
					round_q <= round_q + 4'd1;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// Result valid: set when the last round retires, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run_adv && last_round) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Round data path; first AddRoundKey uses the raw key words.
	always_ff @(posedge clk) begin
		if (accept)
			data_q <= s_tdata ^ offs ^ key_q[191:64];
		else if (run_adv)
			data_q <= rnd_out;
	end

endmodule
